### rtl/gipc_pkg.sv
package gipc_pkg;

	// Grid extent limit and field widths
	localparam int MAX_DIM    = 1024;
	localparam int SIZE_W     = 11;
	localparam int CRD_W      = 10;
	localparam int POS_W      = 12;
	localparam int IDX_W      = 30;
	localparam int PLANE_W    = 21;
	localparam int TOTAL_W    = 31;
	localparam int QUO_W      = 2 * CRD_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int REG_ADDR_W = 2;

	// Request codes
	localparam logic REQ_POS2IDX = 1'b0;
	localparam logic REQ_IDX2POS = 1'b1;

	typedef enum logic [REG_ADDR_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} reg_idx_t;

	// Effective grid geometry, derived from the size registers
	typedef struct packed {
		logic [SIZE_W-1:0]  sx;
		logic [SIZE_W-1:0]  sy;
		logic [SIZE_W-1:0]  sz;
		logic [PLANE_W-1:0] plane;
		logic [TOTAL_W-1:0] total;
	} grid_t;

	// Payload travelling through the division stages
	typedef struct packed {
		logic             req;
		logic             legit;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} pipe_t;

	// Clamp a written extent into 1 .. MAX_DIM
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		priority if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_W'(MAX_DIM)) begin
			r = SIZE_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### rtl/gipc_cfg.sv
module gipc_cfg
	import gipc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [REG_ADDR_W-1:0] cfg_addr,
	input  logic [SIZE_W-1:0]     cfg_wdata,
	output grid_t                 grid
);

	logic [SIZE_W-1:0]         size_x_q;
	logic [SIZE_W-1:0]         size_y_q;
	logic [SIZE_W-1:0]         size_z_q;
	logic [PLANE_W-1:0]        plane_q;
	logic [TOTAL_W-1:0]        total_q;
	logic [SIZE_W-1:0]         sx_eff;
	logic [SIZE_W-1:0]         sy_eff;
	logic [SIZE_W-1:0]         sz_eff;
	logic [2*SIZE_W-1:0]       plane_full;
	logic [SIZE_W+PLANE_W-1:0] total_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(1);
			size_y_q <= SIZE_W'(1);
			size_z_q <= SIZE_W'(1);
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_SIZE_X: size_x_q <= cfg_wdata;
				REG_SIZE_Y: size_y_q <= cfg_wdata;
				REG_SIZE_Z: size_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign sx_eff     = eff_size(size_x_q);
	assign sy_eff     = eff_size(size_y_q);
	assign sz_eff     = eff_size(size_z_q);
	assign plane_full = (2*SIZE_W)'(sy_eff) * (2*SIZE_W)'(sz_eff);
	assign total_full = (SIZE_W+PLANE_W)'(sx_eff) * (SIZE_W+PLANE_W)'(plane_q);

	// Plane is registered from the sizes, total from plane_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_W'(1);
			total_q <= TOTAL_W'(1);
		end else begin
			plane_q <= PLANE_W'(plane_full);
			total_q <= TOTAL_W'(total_full);
		end
	end

	assign grid.sx    = sx_eff;
	assign grid.sy    = sy_eff;
	assign grid.sz    = sz_eff;
	assign grid.plane = plane_q;
	assign grid.total = total_q;

endmodule

### rtl/gipc_front.sv
module gipc_front
	import gipc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic             req_type,
	input  logic [POS_W-1:0] pos_x,
	input  logic [POS_W-1:0] pos_y,
	input  logic [POS_W-1:0] pos_z,
	input  logic [IDX_W-1:0] index_in,
	input  grid_t            grid,
	output logic             vld_s4,
	output pipe_t            pipe_s4
);

	localparam int LIN_A_W = CRD_W + SIZE_W;
	localparam int LIN_B_W = 2 * CRD_W + SIZE_W;

	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;

	logic               req_s1;
	logic [POS_W-1:0]   px_s1;
	logic [POS_W-1:0]   py_s1;
	logic [POS_W-1:0]   pz_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               req_s2;
	logic               inb_s2;
	logic [2*CRD_W-1:0] lin_a_s2;
	logic [CRD_W-1:0]   pz_s2;
	logic [IDX_W-1:0]   idx_s2;

	logic               req_s3;
	logic               inb_s3;
	logic [IDX_W-1:0]   idx0_s3;
	logic [IDX_W-1:0]   idx_s3;

	logic               inb;
	logic [LIN_A_W-1:0] lin_a;
	logic [LIN_B_W-1:0] lin_b;
	logic               legit;
	logic               pos_ok;

	function automatic logic in_ext(input logic [POS_W-1:0] p, input logic [SIZE_W-1:0] s);
		return !p[POS_W-1] && (p[SIZE_W-1:0] < s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 2: bounds check, x*sy + y
	assign inb = in_ext(px_s1, grid.sx) && in_ext(py_s1, grid.sy) && in_ext(pz_s1, grid.sz);
	assign lin_a = LIN_A_W'(px_s1[CRD_W-1:0]) * LIN_A_W'(grid.sy)
		+ LIN_A_W'(py_s1[CRD_W-1:0]);

	// Stage 3: (x*sy + y)*sz + z
	assign lin_b = LIN_B_W'(lin_a_s2) * LIN_B_W'(grid.sz) + LIN_B_W'(pz_s2);

	// Stage 4: index range check against the registered grid total
	assign pos_ok = (req_s3 == REQ_POS2IDX) && inb_s3;
	assign legit  = (req_s3 == REQ_IDX2POS) ? ({1'b0, idx_s3} < grid.total) : inb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= req_type;
			px_s1    <= pos_x;
			py_s1    <= pos_y;
			pz_s1    <= pos_z;
			idx_s1   <= index_in;

			req_s2   <= req_s1;
			inb_s2   <= inb;
			lin_a_s2 <= (2*CRD_W)'(lin_a);
			pz_s2    <= pz_s1[CRD_W-1:0];
			idx_s2   <= idx_s1;

			req_s3   <= req_s2;
			inb_s3   <= inb_s2;
			idx0_s3  <= IDX_W'(lin_b);
			idx_s3   <= idx_s2;

			pipe_s4.req   <= req_s3;
			pipe_s4.legit <= legit;
			pipe_s4.idx   <= pos_ok ? idx0_s3 : '0;
			pipe_s4.rem   <= idx_s3;
			pipe_s4.quo   <= '0;
		end
	end

endmodule

### rtl/gipc_div_stage.sv
module gipc_div_stage
	import gipc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  pipe_t            pipe_in,
	input  logic [IDX_W-1:0] divisor,
	output logic             vld_q,
	output pipe_t            pipe_q
);

	logic  take;
	pipe_t nxt;

	// One restoring step: subtract the shifted divisor if it fits
	always_comb begin
		take     = pipe_in.rem >= divisor;
		nxt      = pipe_in;
		nxt.rem  = take ? (pipe_in.rem - divisor) : pipe_in.rem;
		nxt.quo  = {pipe_in.quo[QUO_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q <= nxt;
		end
	end

endmodule

### rtl/grid3d_index_position_convert_unit.sv
// Converts between a signed 3D grid position and its row-major linear index,
// one conversion per clock. req_type 0 checks (pos_x, pos_y, pos_z) against
// the grid and returns legit and index_out = x*size_y*size_z + y*size_z + z;
// req_type 1 splits index_in into coord_x, coord_y, coord_z and flags an
// index at or beyond size_x*size_y*size_z as not legit. Fields that do not
// apply, and all fields of a result that is not legit, read as zero. Sizes
// are written through the cfg_* port (index 0 x, 1 y, 2 z; other indices are
// dropped); 0 acts as 1 and anything above 1024 acts as 1024. Write sizes
// only while no transfer is in flight. The block is a 25-stage pipeline:
// four stages for capture, bounds check, the two multiply-adds and the index
// range check, twenty restoring division stages that each settle one
// quotient bit (ten for x against size_y*size_z, ten for y against size_z,
// z being the final remainder), and an output register. Throughput is one
// item per cycle except while out_valid is high and out_ready low: then
// the whole pipeline holds, and in_ready drops with it.
module grid3d_index_position_convert_unit
	import gipc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [REG_ADDR_W-1:0] cfg_addr,
	input  logic [SIZE_W-1:0]     cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [POS_W-1:0]      pos_x,
	input  logic [POS_W-1:0]      pos_y,
	input  logic [POS_W-1:0]      pos_z,
	input  logic [IDX_W-1:0]      index_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  legit,
	output logic [IDX_W-1:0]      index_out,
	output logic [CRD_W-1:0]      coord_x,
	output logic [CRD_W-1:0]      coord_y,
	output logic [CRD_W-1:0]      coord_z
);

	grid_t            grid;
	logic             en;
	logic             stg_vld  [DIV_STEPS+1];
	pipe_t            stg_pipe [DIV_STEPS+1];
	logic [IDX_W-1:0] div_dvs  [DIV_STEPS];
	pipe_t            last;
	logic             show_crd;

	logic             out_vld_q;
	logic             legit_q;
	logic [IDX_W-1:0] index_q;
	logic [CRD_W-1:0] cx_q;
	logic [CRD_W-1:0] cy_q;
	logic [CRD_W-1:0] cz_q;

	// Advance everything when the output register is free or being taken
	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	gipc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.grid      (grid)
	);

	gipc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.req_type (req_type),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.index_in (index_in),
		.grid     (grid),
		.vld_s4   (stg_vld[0]),
		.pipe_s4  (stg_pipe[0])
	);

	// First ten steps divide by the plane size, high quotient bit first;
	// the next ten divide the remaining in-plane offset by size_z.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		if (j < CRD_W) begin : g_x
			assign div_dvs[j] = IDX_W'(grid.plane) << (CRD_W - 1 - j);
		end else begin : g_y
			assign div_dvs[j] = IDX_W'(grid.sz) << (QUO_W - 1 - j);
		end

		gipc_div_stage u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (stg_vld[j]),
			.pipe_in (stg_pipe[j]),
			.divisor (div_dvs[j]),
			.vld_q   (stg_vld[j+1]),
			.pipe_q  (stg_pipe[j+1])
		);
	end

	assign last     = stg_pipe[DIV_STEPS];
	assign show_crd = (last.req == REQ_IDX2POS) && last.legit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= stg_vld[DIV_STEPS];
		end
	end

	// Zero the coordinates unless a legit index was split
	always_ff @(posedge clk) begin
		if (en) begin
			legit_q <= last.legit;
			index_q <= last.idx;
			cx_q    <= show_crd ? last.quo[QUO_W-1:CRD_W] : '0;
			cy_q    <= show_crd ? last.quo[CRD_W-1:0] : '0;
			cz_q    <= show_crd ? last.rem[CRD_W-1:0] : '0;
		end
	end

	assign out_valid = out_vld_q;
	assign legit     = legit_q;
	assign index_out = index_q;
	assign coord_x   = cx_q;
	assign coord_y   = cy_q;
	assign coord_z   = cz_q;

endmodule

### bench/tb_grid3d_index_position_convert_unit.sv
`timescale 1ns / 1ps

module tb_grid3d_index_position_convert_unit;
	import gipc_pkg::*;

	// Input transfer to out_valid, in pipeline registers of the block
	localparam int PIPE_LATENCY = 25;
	localparam int IDLE_PCT     = 10;
	localparam int STALL_LIMIT  = 2000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 135;
	localparam int CHOKE_LEN    = 300;
	localparam int DIR_ROWS     = 25;

	// Index with no register behind it; writes there must be dropped
	localparam logic [REG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic             req;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
		logic [IDX_W-1:0] idx;
	} conv_req_t;

	typedef struct packed {
		logic             legit;
		logic [IDX_W-1:0] index;
		logic [CRD_W-1:0] cx;
		logic [CRD_W-1:0] cy;
		logic [CRD_W-1:0] cz;
	} conv_res_t;

	// One directed row: optional regrid, the request, and a typed-in answer where
	// the answer is obvious (typed = 0 leaves it to the predictor)
	typedef struct {
		bit   regrid;
		int   sx, sy, sz;
		logic req;
		int   px, py, pz, idx;
		bit   typed;
		bit   w_legit;
		int   w_index, w_x, w_y, w_z;
	} dir_row_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [REG_ADDR_W-1:0] cfg_addr    = REG_SIZE_X;
	logic [SIZE_W-1:0]     cfg_wdata   = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  req_type    = REQ_POS2IDX;
	logic [POS_W-1:0]      pos_x       = '0;
	logic [POS_W-1:0]      pos_y       = '0;
	logic [POS_W-1:0]      pos_z       = '0;
	logic [IDX_W-1:0]      index_in    = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  legit;
	logic [IDX_W-1:0]      index_out;
	logic [CRD_W-1:0]      coord_x;
	logic [CRD_W-1:0]      coord_y;
	logic [CRD_W-1:0]      coord_z;

	// Our copy of the size registers, raw written bits as the block keeps them
	logic [SIZE_W-1:0] reg_sx = SIZE_W'(1);
	logic [SIZE_W-1:0] reg_sy = SIZE_W'(1);
	logic [SIZE_W-1:0] reg_sz = SIZE_W'(1);

	conv_res_t conv_pending[$];
	dir_row_t  dir_tab[DIR_ROWS];
	int        fail_count   = 0;
	int        stall_cycles = 0;
	int        choke_cycles = 0;
	bit        calm         = 1'b0;

	grid3d_index_position_convert_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.index_in  (index_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.legit     (legit),
		.index_out (index_out),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Effective extent: a zero register acts as one, anything past the limit
	// is clipped to it
	function automatic int unsigned grid_extent(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > SIZE_W'(MAX_DIM)) begin
			return MAX_DIM;
		end
		return 32'(v);
	endfunction

	// Row-major conversion in either direction against the current grid
	function automatic conv_res_t predict_conversion(input conv_req_t q);
		conv_res_t res;
		longint    ex, ey, ez, px, py, pz, plane, idx;
		ex  = longint'(grid_extent(reg_sx));
		ey  = longint'(grid_extent(reg_sy));
		ez  = longint'(grid_extent(reg_sz));
		res = '0;
		if (q.req == REQ_POS2IDX) begin
			px = longint'($signed(q.px));
			py = longint'($signed(q.py));
			pz = longint'($signed(q.pz));
			if (px >= 0 && px < ex && py >= 0 && py < ey && pz >= 0 && pz < ez) begin
				res.legit = 1'b1;
				res.index = IDX_W'(px * ey * ez + py * ez + pz);
			end
		end else begin
			idx   = longint'(q.idx);
			plane = ey * ez;
			if (idx < ex * plane) begin
				res.legit = 1'b1;
				res.cx    = CRD_W'(idx / plane);
				res.cy    = CRD_W'((idx % plane) / ez);
				res.cz    = CRD_W'(idx % ez);
			end
		end
		return res;
	endfunction

	// Coordinate either inside its extent or at or just past its edges / anywhere at all
	function automatic logic [POS_W-1:0] random_coord(input int unsigned ext, input bit in_grid);
		if (in_grid) begin
			return POS_W'($urandom_range(ext - 1));
		end
		case ($urandom_range(3))
			0: begin
				return '1;
			end
			1: begin
				return POS_W'(ext);
			end
			2: begin
				return POS_W'(ext - 1);
			end
			default: begin
				return POS_W'($urandom);
			end
		endcase
	endfunction

	// Mostly well-formed requests with random content, the rest at or past the grid edges or random
	function automatic conv_req_t random_request();
		conv_req_t         q;
		int unsigned       ex, ey, ez;
		longint unsigned   total;
		bit                ok;
		ex    = grid_extent(reg_sx);
		ey    = grid_extent(reg_sy);
		ez    = grid_extent(reg_sz);
		total = longint'(ex) * ey * ez;
		ok    = ($urandom_range(99) < 85);
		q.req = $urandom_range(1) ? REQ_IDX2POS : REQ_POS2IDX;
		q.px  = random_coord(ex, ok);
		q.py  = random_coord(ey, ok);
		q.pz  = random_coord(ez, ok);
		q.idx = IDX_W'($urandom);
		if (q.req == REQ_IDX2POS) begin
			if (ok) begin
				q.idx = IDX_W'($urandom_range(32'(total - 1)));
			end else if ($urandom_range(1)) begin
				// first index past the grid
				q.idx = IDX_W'(total);
			end
		end
		return q;
	endfunction

	function automatic logic [SIZE_W-1:0] random_extent();
		case ($urandom_range(3))
			0: begin
				return SIZE_W'($urandom_range(1, 8));
			end
			1: begin
				return SIZE_W'($urandom_range(1, MAX_DIM));
			end
			2: begin
				// raw register bits, zero and past-the-limit included
				return SIZE_W'($urandom);
			end
			default: begin
				return $urandom_range(1) ? SIZE_W'(MAX_DIM) : SIZE_W'(1);
			end
		endcase
	endfunction

	// Drop valid, wait for every outstanding result, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (conv_pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Regrid while idle; the write to the unused index must change nothing
	task automatic set_grid(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
			input logic [SIZE_W-1:0] sz);
		settle();
		cfg_write(REG_SIZE_X, sx);
		cfg_write(REG_SIZE_Y, sy);
		cfg_write(REG_SIZE_Z, sz);
		cfg_write(REG_UNUSED, SIZE_W'($urandom));
		cfg_wr_en <= 1'b0;
		reg_sx = sx;
		reg_sy = sy;
		reg_sz = sz;
	endtask

	// Offer one request, hold it until the transfer, then log its answer
	task automatic push_item(input conv_req_t q, input conv_res_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= q.req;
		pos_x    <= q.px;
		pos_y    <= q.py;
		pos_z    <= q.pz;
		index_in <= q.idx;
		do @(posedge clk); while (!in_ready);
		conv_pending.push_back(want);
	endtask

	// Receiver: random back-pressure, a quiet stretch, and one long hold-off
	// while the sender keeps offering so the pipe fills and in_ready drops
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (choke_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (choke_cycles) @(posedge clk);
				choke_cycles = 0;
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare every result transfer against the oldest outstanding answer
	always @(posedge clk) begin : check_results
		conv_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (conv_pending.size() == 0) begin
				$error("result transfer with nothing outstanding");
				fail_count++;
			end else begin
				want = conv_pending.pop_front();
				if (legit !== want.legit) begin
					$error("legit: expected %0d, got %0d", want.legit, legit);
					fail_count++;
				end
				if (index_out !== want.index) begin
					$error("index_out: expected %0d, got %0d", want.index, index_out);
					fail_count++;
				end
				if (coord_x !== want.cx) begin
					$error("coord_x: expected %0d, got %0d", want.cx, coord_x);
					fail_count++;
				end
				if (coord_y !== want.cy) begin
					$error("coord_y: expected %0d, got %0d", want.cy, coord_y);
					fail_count++;
				end
				if (coord_z !== want.cz) begin
					$error("coord_z: expected %0d, got %0d", want.cz, coord_z);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: give up after too long with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL grid3d_index_position_convert_unit");
				$finish;
			end
		end
	end

	initial begin
		conv_req_t q;
		conv_res_t want;

		// Columns: regrid sx sy sz | req px py pz idx | typed legit index x y z
		dir_tab = '{
			// reset grid is a single point
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, 0, 0, 0, 1, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, -1, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 0, 0, 1, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			// all-ones registers clip to the full 1024 cube
			'{1'b1, 2047, 2047, 2047, REQ_POS2IDX, 1023, 1023, 1023, 0,
				1'b1, 1'b1, 1073741823, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, 0, 0, 0, 1073741823,
				1'b1, 1'b1, 0, 1023, 1023, 1023},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, -2048, -2048, -2048, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 2047, 2047, 2047, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 1024, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 0, 1024, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 0, 0, 1024, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			// fields the request type does not use must not leak through
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 0, 0, 0, 1073741823, 1'b1, 1'b1, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, -2048, -1, 2047, 0, 1'b1, 1'b1, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 1, 2, 3, 0, 1'b0, 1'b0, 0, 0, 0, 0},
			// zero registers act as one
			'{1'b1, 0, 0, 0, REQ_POS2IDX, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, 0, 0, 0, 1, 1'b1, 1'b0, 0, 0, 0, 0},
			// small uneven grid, last index and just past it
			'{1'b1, 3, 5, 7, REQ_POS2IDX, 2, 4, 6, 0, 1'b0, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, 0, 0, 0, 104, 1'b0, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_IDX2POS, 0, 0, 0, 105, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 1, 2, 3, 0, 1'b0, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 0, 5, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 3, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0},
			// one register just past the limit, one degenerate axis
			'{1'b1, 1024, 1, 1025, REQ_IDX2POS, 0, 0, 0, 1023, 1'b0, 1'b0, 0, 0, 0, 0},
			'{1'b0, 0, 0, 0, REQ_POS2IDX, 1023, 0, 1023, 0, 1'b0, 1'b0, 0, 0, 0, 0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].regrid) begin
				set_grid(SIZE_W'(dir_tab[i].sx), SIZE_W'(dir_tab[i].sy), SIZE_W'(dir_tab[i].sz));
			end
			q.req = dir_tab[i].req;
			q.px  = POS_W'(dir_tab[i].px);
			q.py  = POS_W'(dir_tab[i].py);
			q.pz  = POS_W'(dir_tab[i].pz);
			q.idx = IDX_W'(dir_tab[i].idx);
			if (dir_tab[i].typed) begin
				want.legit = dir_tab[i].w_legit;
				want.index = IDX_W'(dir_tab[i].w_index);
				want.cx    = CRD_W'(dir_tab[i].w_x);
				want.cy    = CRD_W'(dir_tab[i].w_y);
				want.cz    = CRD_W'(dir_tab[i].w_z);
			end else begin
				want = predict_conversion(q);
			end
			push_item(q, want);
		end

		// Random phases: full cube, single point, clipped/zero registers, random grids
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					set_grid(SIZE_W'(MAX_DIM), SIZE_W'(MAX_DIM), SIZE_W'(MAX_DIM));
				end
				1: begin
					set_grid(SIZE_W'(1), SIZE_W'(1), SIZE_W'(1));
				end
				2: begin
					set_grid('1, '0, random_extent());
				end
				default: begin
					set_grid(random_extent(), random_extent(), random_extent());
				end
			endcase
			// one phase at full rate on both sides
			calm = (ph == 3);
			if (ph == 4) begin
				choke_cycles = CHOKE_LEN;
			end
			repeat (PHASE_ITEMS) begin
				q = random_request();
				push_item(q, predict_conversion(q));
			end
		end

		calm = 1'b0;
		settle();
		if (fail_count == 0 && conv_pending.size() == 0) begin
			$display("PASS grid3d_index_position_convert_unit");
		end else begin
			$display("FAIL grid3d_index_position_convert_unit");
		end
		$finish;
	end

endmodule
